// File: hdl/light_angle_interpolator_macros.svh
// Assertion macros for the light angle interpolator.
`ifndef LIGHT_ANGLE_INTERPOLATOR_MACROS_SVH
`define LIGHT_ANGLE_INTERPOLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset.
`define LAI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true out of reset.
`define LAI_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LAI_ASSERT(lbl, clk, rst_n, prop, msg)
`define LAI_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/lai_pkg.sv
// Types, constants and the arctangent table of the light angle interpolator.
package lai_pkg;

  typedef struct packed {
    logic        req_type;
    logic [14:0] dest_theta;
    logic [15:0] dest_phi;
    logic [15:0] dest_intensity;
    logic [15:0] dest_red;
    logic [15:0] dest_green;
    logic [15:0] dest_blue;
    logic [23:0] duration;
    logic [15:0] tick_time;
  } lai_in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [14:0]        theta_now;
    logic [15:0]        phi_now;
    logic [15:0]        intensity_now;
    logic [15:0]        red_now;
    logic [15:0]        green_now;
    logic [15:0]        blue_now;
    logic               busy_res;
  } lai_out_t;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } lai_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_BLEND,
    ST_COS_T,
    ST_COS_P,
    ST_PROD,
    ST_DONE
  } lai_state_e;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Interpolated value slots: angles first, then levels.
  localparam int unsigned LAI_NUM_EL = 6;
  localparam logic [2:0] EL_THETA = 3'd0;
  localparam logic [2:0] EL_PHI   = 3'd1;
  localparam logic [2:0] EL_INT   = 3'd2;
  localparam logic [2:0] EL_RED   = 3'd3;
  localparam logic [2:0] EL_GREEN = 3'd4;
  localparam logic [2:0] EL_BLUE  = 3'd5;

  // CORDIC constants, angles in 2^-29 rad, gain in Q2.30.
  localparam logic signed [33:0] LAI_GAIN    = 34'sd652032874;
  localparam logic signed [33:0] LAI_HALF_PI = 34'sd843314857;
  localparam logic signed [33:0] LAI_PI      = 34'sd1686629713;

  function automatic logic signed [33:0] lai_atan(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/light_angle_interpolator.sv
// Light angle interpolator: keyframe blend of light angles and levels with direction output.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one beat per item: either a
// start beat (captures the current values, stores destination and duration) or a tick
// beat (advances elapsed time and re-blends while a run is active). Every input beat
// produces exactly one result beat on out_valid_o / out_stall_i / out_data_o holding the
// current angles, levels, run flag and the unit direction.
// The block takes one item at a time; in_stall_o is high from acceptance until the
// result is moved into the output register. Per item: an accept step, two CORDIC
// passes of range reduction, rotation and rounding, the two direction products and
// the load into the output register. A tick during a run adds a time-sum step, the
// divider (skipped for a zero duration) and multiply-accumulate steps for six blends.
// The result sits in an output register, so the next item is taken while it waits; a
// stalled receiver only holds back the load of the following result.
// Reset clears all light state to zero and stops any run; the output and direction registers are not reset.
`include "light_angle_interpolator_macros.svh"

module light_angle_interpolator import lai_pkg::*; #(
  parameter int unsigned TIME_BITS     = 24,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned CORDIC_STEPS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lai_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lai_out_t out_data_o
);
  localparam int unsigned TB   = TIME_BITS;
  localparam int unsigned FB   = FRACTION_BITS;
  localparam int unsigned MB   = (FB + 2 > 16) ? FB + 2 : 16;  // multiplier b width
  localparam int unsigned PW   = 17 + MB;
  localparam int unsigned AW   = PW + 1;
  localparam int unsigned SUMW = ((TB > 16) ? TB : 16) + 1;
  localparam logic [FB:0]            FULL  = {1'b1, {FB{1'b0}}};
  localparam logic signed [AW-1:0]   HALF  = AW'(1) << (FB - 1);
  localparam logic signed [AW-1:0]   RND14 = AW'(1) << 13;

  lai_state_e state_q, state_d;

  logic [15:0]        cur_q   [LAI_NUM_EL];
  logic [15:0]        start_q [LAI_NUM_EL];
  logic [15:0]        goal_q  [LAI_NUM_EL];
  logic [TB-1:0]      span_q, elapsed_q, el_d;
  logic [15:0]        tick_q;
  logic               running_q, running_d;
  logic [FB:0]        f_q;
  logic [2:0]         el_q;
  logic               tm_q;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [16:0]   mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [15:0] st_q, ct_q, dx_q, dy_q;
  logic [SUMW-1:0]    sum;
  logic               over, span_zero, in_acc, out_load;
  logic [15:0]        blend_val;
  lai_out_t           out_q;
  logic               out_valid_q;

  lai_sts_t           div_sts, cor_sts;
  logic [FB:0]        div_quo;
  logic               div_start, cor_start;
  logic [15:0]        cor_angle;
  logic signed [15:0] cor_sin, cor_cos;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // elapsed time update, clamped at the duration
  assign sum       = SUMW'(elapsed_q) + SUMW'(tick_q);
  assign over      = sum > SUMW'(span_q);
  assign span_zero = (span_q == '0);
  assign el_d      = over ? span_q : sum[TB-1:0];
  assign running_d = !(over || span_zero);

  // shared multiplier: blend terms, then the two direction products
  always_comb begin
    if (state_q == ST_PROD) begin
      mul_a = 17'(st_q);
      mul_b = MB'(tm_q ? cor_sin : cor_cos);
    end else begin
      mul_a = {1'b0, tm_q ? goal_q[el_q] : start_q[el_q]};
      mul_b = tm_q ? MB'(f_q) : MB'(FULL - f_q);
    end
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    if (state_q == ST_PROD)  acc_d = RND14 + AW'(prod);
    else if (tm_q)           acc_d = acc_q + AW'(prod);
    else                     acc_d = HALF + AW'(prod);
  end
  assign blend_val = acc_d[FB+15:FB];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type == REQ_START || !running_q) state_d = ST_COS_T;
          else                                               state_d = ST_SUM;
        end
      end
      ST_SUM:   state_d = span_zero ? ST_BLEND : ST_DIV;
      ST_DIV:   if (div_sts.done) state_d = ST_BLEND;
      ST_BLEND: if (tm_q && el_q == EL_BLUE) state_d = ST_COS_T;
      ST_COS_T: if (cor_sts.done) state_d = ST_COS_P;
      ST_COS_P: if (cor_sts.done) state_d = ST_PROD;
      ST_PROD:  if (tm_q) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit launches
  always_comb begin
    div_start = (state_q == ST_SUM) && !span_zero;
    cor_start = ((state_q != ST_COS_T) && (state_d == ST_COS_T)) ||
                ((state_q == ST_COS_T) && (state_d == ST_COS_P));
    cor_angle = (state_d == ST_COS_P) ? cur_q[EL_PHI] : {1'b0, cur_q[EL_THETA][14:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      span_q      <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      el_q        <= '0;
      tm_q        <= 1'b0;
      for (int i = 0; i < LAI_NUM_EL; i++) begin
        cur_q[i]   <= '0;
        start_q[i] <= '0;
        goal_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load)                      out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      if (in_acc && in_data_i.req_type == REQ_START) begin
        for (int i = 0; i < LAI_NUM_EL; i++) start_q[i] <= cur_q[i];
        goal_q[EL_THETA] <= {1'b0, in_data_i.dest_theta};
        goal_q[EL_PHI]   <= in_data_i.dest_phi;
        goal_q[EL_INT]   <= in_data_i.dest_intensity;
        goal_q[EL_RED]   <= in_data_i.dest_red;
        goal_q[EL_GREEN] <= in_data_i.dest_green;
        goal_q[EL_BLUE]  <= in_data_i.dest_blue;
        span_q    <= TB'(in_data_i.duration);
        elapsed_q <= '0;
        running_q <= 1'b1;
      end

      if (state_q == ST_SUM) begin
        elapsed_q <= el_d;
        running_q <= running_d;
        el_q      <= EL_THETA;
        tm_q      <= 1'b0;
      end

      if (state_q == ST_BLEND) begin
        tm_q <= ~tm_q;
        if (tm_q) begin
          cur_q[el_q] <= (el_q == EL_THETA) ? {1'b0, blend_val[14:0]} : blend_val;
          el_q        <= el_q + 1'b1;
        end
      end

      if (state_q == ST_COS_P && cor_sts.done) tm_q <= 1'b0;
      if (state_q == ST_PROD) tm_q <= ~tm_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) tick_q <= in_data_i.tick_time;
    if (state_q == ST_SUM && span_zero) f_q <= FULL;
    if (state_q == ST_DIV && div_sts.done) f_q <= div_quo;
    if (state_q == ST_BLEND || state_q == ST_PROD) acc_q <= acc_d;
    if (state_q == ST_COS_T && cor_sts.done) begin
      st_q <= cor_sin;
      ct_q <= cor_cos;
    end
    if (state_q == ST_PROD) begin
      if (tm_q) dy_q <= acc_d[29:14];
      else      dx_q <= acc_d[29:14];
    end
    if (out_load) begin
      out_q.dir_x         <= dx_q;
      out_q.dir_y         <= dy_q;
      out_q.dir_z         <= ct_q;
      out_q.theta_now     <= cur_q[EL_THETA][14:0];
      out_q.phi_now       <= cur_q[EL_PHI];
      out_q.intensity_now <= cur_q[EL_INT];
      out_q.red_now       <= cur_q[EL_RED];
      out_q.green_now     <= cur_q[EL_GREEN];
      out_q.blue_now      <= cur_q[EL_BLUE];
      out_q.busy_res      <= running_q;
    end
  end

  lai_div #(
    .TIME_BITS    (TIME_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (el_d),
    .den_i  (span_q),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  lai_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cor_start),
    .angle_i(cor_angle),
    .sts_o  (cor_sts),
    .sin_o  (cor_sin),
    .cos_o  (cor_cos)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LAI_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_DONE, "result loaded outside done state")
  `LAI_ASSERT(a_elapsed_le_span, clk_i, rst_ni, elapsed_q <= span_q, "elapsed time past duration")
  `LAI_ASSERT(a_fraction_range, clk_i, rst_ni, (state_q == ST_BLEND) |-> (f_q <= FULL), "fraction above one")
  `LAI_NEVER(a_idle_unit_busy, clk_i, rst_ni, (state_q == ST_IDLE) && (div_sts.busy || cor_sts.busy), "arithmetic unit busy while idle")
endmodule

// File: hdl/lai_div.sv
// Restoring divider for the interpolation fraction, one quotient bit per cycle.
module lai_div import lai_pkg::*; #(
  parameter int unsigned TIME_BITS     = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TIME_BITS-1:0]   num_i,
  input  logic [TIME_BITS-1:0]   den_i,
  output lai_sts_t               sts_o,
  output logic [FRACTION_BITS:0] quo_o
);
  localparam int unsigned TB  = TIME_BITS;
  localparam int unsigned QW  = FRACTION_BITS + 1;
  localparam int unsigned CNW = $clog2(QW + 1);

  logic [TB:0]     rem_q, trial, diff;
  logic [TB-1:0]   den_q;
  logic [QW-1:0]   quo_q;
  logic [CNW-1:0]  cnt_q;
  logic            busy_q, done_q, first_q, ge;

  // First step compares the numerator as is (quotient may reach 2^FB).
  assign trial = first_q ? rem_q : {rem_q[TB-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= CNW'(QW);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : trial;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign quo_o = quo_q;
endmodule

// File: hdl/lai_cordic.sv
// Iterative rotation CORDIC: sine and cosine of one angle in Q1.14.
module lai_cordic import lai_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output lai_sts_t           sts_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  logic signed [33:0] x_q, y_q, z_q, xs, ys, at, xf, yf;
  logic signed [15:0] sin_q, cos_q;
  logic [SW-1:0]      step_q;
  logic               busy_q, rot_q, fin_q, done_q, flip_q;

  function automatic logic signed [15:0] round_clamp(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) r = 34'sd16384;
    if (r < -34'sd16384) r = -34'sd16384;
    return 16'(r);
  endfunction

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign at = lai_atan(5'(step_q));
  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rot_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rot_q  <= 1'b0;
        fin_q  <= 1'b0;
        step_q <= '0;
      end else if (busy_q && fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end else if (busy_q && rot_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(CORDIC_STEPS - 1)) begin
          rot_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (busy_q && !(z_q > LAI_HALF_PI)) begin
        rot_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      z_q    <= {2'b00, angle_i, 16'h0000};
      x_q    <= LAI_GAIN;
      y_q    <= '0;
      flip_q <= 1'b0;
    end else if (busy_q && fin_q) begin
      cos_q <= round_clamp(xf);
      sin_q <= round_clamp(yf);
    end else if (busy_q && rot_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end else if (busy_q && (z_q > LAI_HALF_PI)) begin
      // range reduction: one half turn per cycle
      z_q    <= z_q - LAI_PI;
      flip_q <= ~flip_q;
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule
